### rtl/hilbert_rtree_node_store_macros.svh
// Assertion macros for the Hilbert R-tree node store checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef HILBERT_RTREE_NODE_STORE_MACROS_SVH
`define HILBERT_RTREE_NODE_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HRNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HRNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hrns_pkg.sv
// Shared codes for the Hilbert R-tree node store: item kinds and result status.
// No dependencies.
`timescale 1ns / 1ps

package hrns_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

endpackage

### rtl/hrns_if.sv
// Valid/ready channel interfaces for node store items and results.
// Depends on hrns_pkg.
`timescale 1ns / 1ps

interface hrns_in_if
  import hrns_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int COORD_BITS  = 16
);
  localparam int IDX_W = $clog2(MAX_ENTRIES);

  logic                         valid;
  logic                         ready;
  kind_t                        kind;
  logic [KEY_BITS-1:0]          entry_key;
  logic signed [COORD_BITS-1:0] box_upper_x;
  logic signed [COORD_BITS-1:0] box_upper_y;
  logic signed [COORD_BITS-1:0] box_lower_x;
  logic signed [COORD_BITS-1:0] box_lower_y;
  logic [IDX_W-1:0]             read_index;

  modport source (
    output valid, kind, entry_key, box_upper_x, box_upper_y, box_lower_x,
           box_lower_y, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_key, box_upper_x, box_upper_y, box_lower_x,
           box_lower_y, read_index,
    output ready
  );
endinterface

interface hrns_out_if
  import hrns_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int COORD_BITS  = 16
);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic                         valid;
  logic                         ready;
  logic [KEY_BITS-1:0]          key_out;
  logic signed [COORD_BITS-1:0] out_upper_x;
  logic signed [COORD_BITS-1:0] out_upper_y;
  logic signed [COORD_BITS-1:0] out_lower_x;
  logic signed [COORD_BITS-1:0] out_lower_y;
  logic [CNT_W-1:0]             entry_count;
  logic                         has_room;
  logic [IDX_W-1:0]             position;
  status_t                      status;

  modport source (
    output valid, key_out, out_upper_x, out_upper_y, out_lower_x, out_lower_y,
           entry_count, has_room, position, status,
    input  ready
  );
  modport sink (
    input  valid, key_out, out_upper_x, out_upper_y, out_lower_x, out_lower_y,
           entry_count, has_room, position, status,
    output ready
  );
endinterface

### rtl/hrns_slot_mem.sv
// Slot memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hrns_slot_mem #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/hilbert_rtree_node_store.sv
// Hilbert R-tree leaf node store: keeps up to MAX_ENTRIES entries (key plus
// rectangle) sorted by key in one slot memory, and answers clear, insert and
// read items with one result item each. Items are taken one at a time; a new
// item is accepted while the previous result still waits on the output.
// Clear, unused kind, rejected insert and insert into an empty node go from
// the accepting state straight to the result state; a read first passes one
// memory read state; an insert into a node holding N entries walks down from
// the top slot one slot per cycle, shifting each larger entry up by one, and
// places the new entry in slot 0 if its key is the smallest; the walk is paced
// by the one read and one write port of the slot memory. Node largest key and
// bounding box are kept in registers and updated on accept, so no summary
// pass is needed.
// Slots are not cleared after reset; data from slots at or above the count is never used.
// default_lhv (cfg_we/cfg_wdata) is picked up at the next clear.
// Depends on hrns_pkg, hrns_if, hrns_slot_mem.
`timescale 1ns / 1ps

module hilbert_rtree_node_store
  import hrns_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int COORD_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [KEY_BITS-1:0] cfg_wdata,
  hrns_in_if.sink             in_ch,
  hrns_out_if.source          out_ch
);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = KEY_BITS + 4 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ux;
    logic signed [COORD_BITS-1:0] uy;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
  } box_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    box_t                box;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_READ,   // slot data for a read arrives
    S_WALK,   // insert: compare and shift one slot per cycle
    S_PLACE,  // insert: new entry lands in slot 0
    S_DONE    // result ready, waiting for the output register
  } state_t;

  // Control state
  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [KEY_BITS-1:0] max_key_r;
  box_t                bounds_r;
  logic [KEY_BITS-1:0] lhv_r;
  logic                out_valid_r;

  // Item and result payload
  entry_t              new_entry_r;
  logic [IDX_W-1:0]    cur_r;
  logic                idx_ok_r;
  logic [KEY_BITS-1:0] res_key_r;
  box_t                res_box_r;
  logic [IDX_W-1:0]    res_pos_r;
  status_t             res_status_r;
  logic [KEY_BITS-1:0] out_key_r;
  box_t                out_box_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_room_r;
  logic [IDX_W-1:0]    out_pos_r;
  status_t             out_status_r;

  // Memory ports
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENT_W-1:0]    mem_rdata;

  logic                in_fire;
  logic                full;
  logic                empty;
  logic                out_free;
  logic                walk_shift;
  logic [CNT_W-1:0]    cnt_m1;
  entry_t              in_entry;
  entry_t              rd_entry;
  box_t                merged_box;
  box_t                ins_box;
  logic [KEY_BITS-1:0] ins_max;

  hrns_slot_mem #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_ENTRIES));
  assign empty       = (count_r == '0);
  assign cnt_m1      = count_r - 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign rd_entry    = entry_t'(mem_rdata);
  assign walk_shift  = (new_entry_r.key < rd_entry.key);

  assign in_entry.key    = in_ch.entry_key;
  assign in_entry.box.ux = in_ch.box_upper_x;
  assign in_entry.box.uy = in_ch.box_upper_y;
  assign in_entry.box.lx = in_ch.box_lower_x;
  assign in_entry.box.ly = in_ch.box_lower_y;

  // Inserts only grow the node, so the summary merges in the new entry.
  always_comb begin
    merged_box.ux = (in_entry.box.ux > bounds_r.ux) ? in_entry.box.ux : bounds_r.ux;
    merged_box.uy = (in_entry.box.uy > bounds_r.uy) ? in_entry.box.uy : bounds_r.uy;
    merged_box.lx = (in_entry.box.lx < bounds_r.lx) ? in_entry.box.lx : bounds_r.lx;
    merged_box.ly = (in_entry.box.ly < bounds_r.ly) ? in_entry.box.ly : bounds_r.ly;
    ins_box       = empty ? in_entry.box : merged_box;
    ins_max       = (empty || (in_entry.key > max_key_r)) ? in_entry.key : max_key_r;
  end

  // Slot memory access. The walk writes slot cur+1 and reads slot cur-1,
  // so read and write never hit the same slot in one cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_entry_r;
    mem_raddr = cur_r - 1'b1;
    unique case (state_r)
      S_IDLE: begin
        mem_raddr = (in_ch.kind == KIND_READ) ? in_ch.read_index : cnt_m1[IDX_W-1:0];
        if (in_fire && (in_ch.kind == KIND_INSERT) && empty) begin
          mem_we    = 1'b1;
          mem_wdata = in_entry;
        end
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r + 1'b1;
        mem_wdata = walk_shift ? mem_rdata : new_entry_r;
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_READ, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // FSM, node summary and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_key_r   <= '0;
      bounds_r    <= '0;
      lhv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lhv_r <= cfg_wdata;
      end
      // in S_DONE the output register is free here and gets reloaded below
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.kind)
              KIND_CLEAR: begin
                count_r   <= '0;
                max_key_r <= lhv_r;
                bounds_r  <= '0;
                state_r   <= S_DONE;
              end
              KIND_INSERT: begin
                if (full) begin
                  state_r <= S_DONE;
                end else begin
                  count_r   <= count_r + 1'b1;
                  max_key_r <= ins_max;
                  bounds_r  <= ins_box;
                  state_r   <= empty ? S_DONE : S_WALK;
                end
              end
              KIND_READ: state_r <= S_READ;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_READ: state_r <= S_DONE;
        S_WALK: begin
          if (!walk_shift) begin
            state_r <= S_DONE;
          end else if (cur_r == '0) begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item, result and output payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          new_entry_r <= in_entry;
          cur_r       <= cnt_m1[IDX_W-1:0];
          idx_ok_r    <= (CNT_W'(in_ch.read_index) < count_r);
          res_pos_r   <= '0;
          case (in_ch.kind)
            KIND_CLEAR: begin
              res_key_r    <= lhv_r;
              res_box_r    <= '0;
              res_status_r <= STAT_OK;
            end
            KIND_INSERT: begin
              if (full) begin
                res_key_r    <= max_key_r;
                res_box_r    <= bounds_r;
                res_status_r <= STAT_FULL;
              end else begin
                res_key_r    <= ins_max;
                res_box_r    <= ins_box;
                res_status_r <= STAT_OK;
              end
            end
            KIND_READ: begin
              res_status_r <= STAT_OK;
            end
            default: begin
              res_key_r    <= max_key_r;
              res_box_r    <= bounds_r;
              res_status_r <= STAT_OK;
            end
          endcase
        end
      end
      S_READ: begin
        if (idx_ok_r) begin
          res_key_r    <= rd_entry.key;
          res_box_r    <= rd_entry.box;
          res_status_r <= STAT_OK;
        end else begin
          res_key_r    <= '0;
          res_box_r    <= '0;
          res_status_r <= STAT_BAD_INDEX;
        end
      end
      S_WALK: begin
        cur_r <= cur_r - 1'b1;
        if (!walk_shift) begin
          res_pos_r <= cur_r + 1'b1;
        end
      end
      S_PLACE: begin
        res_pos_r <= '0;
      end
      S_DONE: begin
        if (out_free) begin
          out_key_r    <= res_key_r;
          out_box_r    <= res_box_r;
          out_count_r  <= count_r;
          out_room_r   <= (count_r < CNT_W'(MAX_ENTRIES));
          out_pos_r    <= res_pos_r;
          out_status_r <= res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.out_upper_x = out_box_r.ux;
  assign out_ch.out_upper_y = out_box_r.uy;
  assign out_ch.out_lower_x = out_box_r.lx;
  assign out_ch.out_lower_y = out_box_r.ly;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.has_room    = out_room_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.status      = out_status_r;

endmodule

### rtl/hrns_checker.sv
// Port-level checks on node store results, bound to the top level.
// Depends on hrns_pkg and hilbert_rtree_node_store_macros.svh.
`timescale 1ns / 1ps
`include "hilbert_rtree_node_store_macros.svh"

module hrns_checker
  import hrns_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int COORD_BITS  = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [KEY_BITS-1:0]           key_out,
  input logic signed [COORD_BITS-1:0]  out_upper_x,
  input logic signed [COORD_BITS-1:0]  out_upper_y,
  input logic signed [COORD_BITS-1:0]  out_lower_x,
  input logic signed [COORD_BITS-1:0]  out_lower_y,
  input logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
  input logic                          has_room,
  input logic [$clog2(MAX_ENTRIES)-1:0] position,
  input status_t                       status
);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Stalled result holds.
  `HRNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_out) && $stable(entry_count) && $stable(position) && $stable(status), "hrns: stalled result changed")

  // Room flag agrees with the count, count never passes capacity.
  `HRNS_ASSERT_NOW(a_room_count, out_valid, (has_room == (entry_count < CNT_W'(MAX_ENTRIES))) && (entry_count <= CNT_W'(MAX_ENTRIES)), "hrns: room flag or count wrong")

  // A rejected insert only happens on a full node.
  `HRNS_ASSERT_NOW(a_full_reject, out_valid && (status == STAT_FULL), (entry_count == CNT_W'(MAX_ENTRIES)) && (position == '0), "hrns: reject on non-full node")

  // A bad read reports a zero entry.
  `HRNS_ASSERT_NOW(a_bad_read, out_valid && (status == STAT_BAD_INDEX), (key_out == '0) && (out_upper_x == '0) && (out_upper_y == '0) && (out_lower_x == '0) && (out_lower_y == '0) && (position == '0), "hrns: bad read not zeroed")

endmodule

bind hilbert_rtree_node_store hrns_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .KEY_BITS    (KEY_BITS),
  .COORD_BITS  (COORD_BITS)
) u_hrns_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .key_out     (out_ch.key_out),
  .out_upper_x (out_ch.out_upper_x),
  .out_upper_y (out_ch.out_upper_y),
  .out_lower_x (out_ch.out_lower_x),
  .out_lower_y (out_ch.out_lower_y),
  .entry_count (out_ch.entry_count),
  .has_room    (out_ch.has_room),
  .position    (out_ch.position),
  .status      (out_ch.status)
);
